[rtl/core/ace_pkg.sv]
package ace_pkg;

  localparam int CODE_DEPTH = 4096;
  localparam int IDX_W      = $clog2(CODE_DEPTH);
  localparam int FILL_W     = $clog2(CODE_DEPTH + 1);
  localparam int CMP_W      = (FILL_W > 13) ? FILL_W : 13;

  localparam logic [4:0] REQ_MOVZ    = 5'd0;
  localparam logic [4:0] REQ_MOVK    = 5'd1;
  localparam logic [4:0] REQ_MOV     = 5'd2;
  localparam logic [4:0] REQ_ADD     = 5'd3;
  localparam logic [4:0] REQ_SUB     = 5'd4;
  localparam logic [4:0] REQ_ADDS_W  = 5'd5;
  localparam logic [4:0] REQ_SUBS_W  = 5'd6;
  localparam logic [4:0] REQ_MUL     = 5'd7;
  localparam logic [4:0] REQ_ADD_IMM = 5'd8;
  localparam logic [4:0] REQ_SUB_IMM = 5'd9;
  localparam logic [4:0] REQ_CMP     = 5'd10;
  localparam logic [4:0] REQ_CSET    = 5'd11;
  localparam logic [4:0] REQ_LDR     = 5'd12;
  localparam logic [4:0] REQ_STR     = 5'd13;
  localparam logic [4:0] REQ_B       = 5'd14;
  localparam logic [4:0] REQ_BCOND   = 5'd15;
  localparam logic [4:0] REQ_FMOV_DX = 5'd16;
  localparam logic [4:0] REQ_FMOV_XD = 5'd17;
  localparam logic [4:0] REQ_FADD    = 5'd18;
  localparam logic [4:0] REQ_FSUB    = 5'd19;
  localparam logic [4:0] REQ_FMUL    = 5'd20;
  localparam logic [4:0] REQ_FDIV    = 5'd21;
  localparam logic [4:0] REQ_FCMP    = 5'd22;
  localparam logic [4:0] REQ_SCVTF   = 5'd23;
  localparam logic [4:0] REQ_FCVTZS  = 5'd24;
  localparam logic [4:0] REQ_BLR     = 5'd25;
  localparam logic [4:0] REQ_SXTW    = 5'd26;
  localparam logic [4:0] REQ_RET     = 5'd27;
  localparam logic [4:0] REQ_PATCH   = 5'd28;
  localparam logic [4:0] REQ_CONST64 = 5'd29;
  localparam logic [4:0] REQ_CLEAR   = 5'd30;

  localparam logic [1:0] STATUS_OK    = 2'd0;
  localparam logic [1:0] STATUS_BAD   = 2'd1;
  localparam logic [1:0] STATUS_FULL  = 2'd2;
  localparam logic [1:0] STATUS_PATCH = 2'd3;

  localparam logic [31:0] OPC_MOVZ      = 32'hD2800000;
  localparam logic [31:0] OPC_MOVK      = 32'hF2800000;
  localparam logic [31:0] OPC_CSET      = 32'h9A9F07E0;
  localparam logic [31:0] OPC_B         = 32'h14000000;
  localparam logic [31:0] OPC_BCOND     = 32'h54000000;
  localparam logic [31:0] MASK_KEEP_B19 = 32'hFF00001F;
  localparam logic [31:0] MASK_KEEP_B26 = 32'hFC000000;
  localparam logic [31:0] OPC_RET       = 32'hD65F03C0;
  localparam logic [31:0] OPC_FADD      = 32'h1E602800;
  localparam logic [3:0]  COND_MAX      = 4'd13;

  typedef enum logic [1:0] {
    KIND_SINGLE,
    KIND_CONST,
    KIND_PATCH
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_CONST,
    ST_PATCH
  } state_e;

  typedef struct packed {
    logic       capture;
    logic       emit_single;
    logic       emit_const;
    logic       patch_read;
    logic       emit_patch;
    logic [1:0] part;
  } ctrl_cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  slot_free;
    logic  store_full;
  } dp_stat_t;

endpackage

[rtl/core/ace_req_if.sv]
interface ace_req_if;
  logic        valid;
  logic        ready;
  logic [4:0]  req_type;
  logic [4:0]  dest_reg;
  logic [4:0]  src_reg_a;
  logic [4:0]  src_reg_b;
  logic [15:0] imm_value;
  logic [5:0]  shift_amount;
  logic signed [31:0] branch_offset;
  logic [3:0]  cond_code;
  logic [63:0] wide_value;
  logic [11:0] patch_at;
  logic [12:0] patch_target;
  logic        patch_conditional;

  modport source (
    output valid, req_type, dest_reg, src_reg_a, src_reg_b, imm_value, shift_amount,
           branch_offset, cond_code, wide_value, patch_at, patch_target, patch_conditional,
    input  ready
  );
  modport sink (
    input  valid, req_type, dest_reg, src_reg_a, src_reg_b, imm_value, shift_amount,
           branch_offset, cond_code, wide_value, patch_at, patch_target, patch_conditional,
    output ready
  );
endinterface

[rtl/core/ace_res_if.sv]
interface ace_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] code_word;
  logic [11:0] word_index;
  logic [1:0]  status;
  logic        last;

  modport source (output valid, code_word, word_index, status, last, input ready);
  modport sink (input valid, code_word, word_index, status, last, output ready);
endinterface

[rtl/core/ace_ctrl.sv]
module ace_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  ace_pkg::dp_stat_t  stat_i,
  output ace_pkg::ctrl_cmd_t cmd_o
);

  ace_pkg::state_e state_q, state_d;
  logic [1:0]      part_q, part_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ace_pkg::ST_IDLE;
      part_q  <= '0;
    end else begin
      state_q <= state_d;
      part_q  <= part_d;
    end
  end

  always_comb begin
    state_d = state_q;
    part_d  = part_q;
    unique case (state_q)
      ace_pkg::ST_IDLE: begin
        part_d = '0;
        if (in_valid_i) state_d = ace_pkg::ST_EXEC;
      end
      ace_pkg::ST_EXEC: begin
        unique case (stat_i.kind)
          ace_pkg::KIND_CONST: state_d = ace_pkg::ST_CONST;
          ace_pkg::KIND_PATCH: state_d = ace_pkg::ST_PATCH;
          default: if (stat_i.slot_free) state_d = ace_pkg::ST_IDLE;
        endcase
      end
      ace_pkg::ST_CONST: begin
        if (stat_i.slot_free) begin
          if (stat_i.store_full || part_q == 2'd3) begin
            state_d = ace_pkg::ST_IDLE;
          end else begin
            part_d = part_q + 2'd1;
          end
        end
      end
      ace_pkg::ST_PATCH: begin
        if (stat_i.slot_free) state_d = ace_pkg::ST_IDLE;
      end
      default: state_d = ace_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    cmd_o      = '0;
    cmd_o.part = part_q;
    unique case (state_q)
      ace_pkg::ST_IDLE: begin
        in_ready_o    = 1'b1;
        cmd_o.capture = in_valid_i;
      end
      ace_pkg::ST_EXEC: begin
        cmd_o.emit_single = (stat_i.kind == ace_pkg::KIND_SINGLE) && stat_i.slot_free;
        cmd_o.patch_read  = (stat_i.kind == ace_pkg::KIND_PATCH);
      end
      ace_pkg::ST_CONST: cmd_o.emit_const = stat_i.slot_free;
      ace_pkg::ST_PATCH: cmd_o.emit_patch = stat_i.slot_free;
      default: ;
    endcase
  end

endmodule

[rtl/core/ace_dpath.sv]
module ace_dpath (
  input  logic               clk_i,
  input  logic               rst_ni,
  ace_req_if.sink            req_i,
  ace_res_if.source          res_o,
  input  ace_pkg::ctrl_cmd_t cmd_i,
  output ace_pkg::dp_stat_t  stat_o
);

  typedef struct packed {
    logic [4:0]  req_type;
    logic [4:0]  rd;
    logic [4:0]  rn;
    logic [4:0]  rm;
    logic [15:0] imm;
    logic [5:0]  sh;
    logic [31:0] off;
    logic [3:0]  cc;
    logic [63:0] wide;
    logic [11:0] at;
    logic [12:0] target;
    logic        cond;
  } req_t;

  req_t r_q;

  logic [31:0] code_store [ace_pkg::CODE_DEPTH];
  logic [31:0] rd_data_q;

  logic [ace_pkg::FILL_W-1:0] fill_q, fill_d;
  logic                       out_valid_q;
  logic [31:0]                word_q, word_d;
  logic [11:0]                index_q, index_d;
  logic [1:0]                 status_q, status_d;
  logic                       last_q, last_d;

  logic                       wr_en;
  logic [ace_pkg::IDX_W-1:0]  wr_addr;
  logic [31:0]                wr_data;

  logic [31:0] enc_word;
  logic        enc_bad;
  logic [31:0] const_word;
  logic [15:0] const_part;
  logic        full;
  logic        slot_free;
  logic        patch_bad;
  logic signed [13:0] delta;
  logic [31:0] patch_word;
  logic        emit;

  assign full      = (fill_q == ace_pkg::FILL_W'(ace_pkg::CODE_DEPTH));
  assign slot_free = !out_valid_q || res_o.ready;
  assign emit      = cmd_i.emit_single || cmd_i.emit_const || cmd_i.emit_patch;

  always_comb begin
    if (r_q.req_type == ace_pkg::REQ_PATCH) begin
      stat_o.kind = ace_pkg::KIND_PATCH;
    end else if (r_q.req_type == ace_pkg::REQ_CONST64) begin
      stat_o.kind = ace_pkg::KIND_CONST;
    end else begin
      stat_o.kind = ace_pkg::KIND_SINGLE;
    end
    stat_o.slot_free  = slot_free;
    stat_o.store_full = full;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      r_q.req_type <= req_i.req_type;
      r_q.rd       <= req_i.dest_reg;
      r_q.rn       <= req_i.src_reg_a;
      r_q.rm       <= req_i.src_reg_b;
      r_q.imm      <= req_i.imm_value;
      r_q.sh       <= req_i.shift_amount;
      r_q.off      <= req_i.branch_offset;
      r_q.cc       <= req_i.cond_code;
      r_q.wide     <= req_i.wide_value;
      r_q.at       <= req_i.patch_at;
      r_q.target   <= req_i.patch_target;
      r_q.cond     <= req_i.patch_conditional;
    end
  end

  // instruction encoder
  always_comb begin
    enc_word = '0;
    enc_bad  = 1'b0;
    unique case (r_q.req_type) inside
      ace_pkg::REQ_MOVZ, ace_pkg::REQ_MOVK: begin
        enc_bad  = (r_q.sh > 6'd48) || (r_q.sh[3:0] != 4'd0);
        enc_word = ((r_q.req_type == ace_pkg::REQ_MOVZ) ? ace_pkg::OPC_MOVZ : ace_pkg::OPC_MOVK)
                 | {9'd0, r_q.sh[5:4], r_q.imm, r_q.rd};
      end
      ace_pkg::REQ_MOV:    enc_word = 32'hAA0003E0 | {11'd0, r_q.rn, 11'd0, r_q.rd};
      ace_pkg::REQ_ADD:    enc_word = 32'h8B000000 | {11'd0, r_q.rm, 6'd0, r_q.rn, r_q.rd};
      ace_pkg::REQ_SUB:    enc_word = 32'hCB000000 | {11'd0, r_q.rm, 6'd0, r_q.rn, r_q.rd};
      ace_pkg::REQ_ADDS_W: enc_word = 32'h2B000000 | {11'd0, r_q.rm, 6'd0, r_q.rn, r_q.rd};
      ace_pkg::REQ_SUBS_W: enc_word = 32'h6B000000 | {11'd0, r_q.rm, 6'd0, r_q.rn, r_q.rd};
      ace_pkg::REQ_MUL:    enc_word = 32'h9B007C00 | {11'd0, r_q.rm, 6'd0, r_q.rn, r_q.rd};
      ace_pkg::REQ_ADD_IMM, ace_pkg::REQ_SUB_IMM: begin
        enc_bad  = (r_q.imm[15:12] != 4'd0);
        enc_word = ((r_q.req_type == ace_pkg::REQ_ADD_IMM) ? 32'h91000000 : 32'hD1000000)
                 | {10'd0, r_q.imm[11:0], r_q.rn, r_q.rd};
      end
      ace_pkg::REQ_CMP:    enc_word = 32'hEB00001F | {11'd0, r_q.rm, 6'd0, r_q.rn, 5'd0};
      ace_pkg::REQ_CSET: begin
        enc_bad  = (r_q.cc > ace_pkg::COND_MAX);
        enc_word = ace_pkg::OPC_CSET | {16'd0, r_q.cc ^ 4'd1, 7'd0, r_q.rd};
      end
      ace_pkg::REQ_LDR, ace_pkg::REQ_STR: begin
        enc_bad  = (r_q.imm[2:0] != 3'd0) || r_q.imm[15];
        enc_word = ((r_q.req_type == ace_pkg::REQ_LDR) ? 32'hF9400000 : 32'hF9000000)
                 | {10'd0, r_q.imm[14:3], r_q.rn, r_q.rd};
      end
      ace_pkg::REQ_B: begin
        enc_bad  = (r_q.off[1:0] != 2'd0)
                || !((r_q.off[31:27] == 5'h00) || (r_q.off[31:27] == 5'h1F));
        enc_word = ace_pkg::OPC_B | {6'd0, r_q.off[27:2]};
      end
      ace_pkg::REQ_BCOND: begin
        enc_bad  = (r_q.off[1:0] != 2'd0) || (r_q.cc > ace_pkg::COND_MAX)
                || !((r_q.off[31:20] == 12'h000) || (r_q.off[31:20] == 12'hFFF));
        enc_word = ace_pkg::OPC_BCOND | {8'd0, r_q.off[20:2], 1'b0, r_q.cc};
      end
      ace_pkg::REQ_FMOV_DX: enc_word = 32'h9E670000 | {22'd0, r_q.rn, r_q.rd};
      ace_pkg::REQ_FMOV_XD: enc_word = 32'h9E660000 | {22'd0, r_q.rn, r_q.rd};
      ace_pkg::REQ_FADD:   enc_word = ace_pkg::OPC_FADD | {11'd0, r_q.rm, 6'd0, r_q.rn, r_q.rd};
      ace_pkg::REQ_FSUB:   enc_word = 32'h1E603800 | {11'd0, r_q.rm, 6'd0, r_q.rn, r_q.rd};
      ace_pkg::REQ_FMUL:   enc_word = 32'h1E600800 | {11'd0, r_q.rm, 6'd0, r_q.rn, r_q.rd};
      ace_pkg::REQ_FDIV:   enc_word = 32'h1E601800 | {11'd0, r_q.rm, 6'd0, r_q.rn, r_q.rd};
      ace_pkg::REQ_FCMP:   enc_word = 32'h1E602000 | {11'd0, r_q.rm, 6'd0, r_q.rn, 5'd0};
      ace_pkg::REQ_SCVTF:  enc_word = 32'h9E620000 | {22'd0, r_q.rn, r_q.rd};
      ace_pkg::REQ_FCVTZS: enc_word = 32'h9E780000 | {22'd0, r_q.rn, r_q.rd};
      ace_pkg::REQ_BLR:    enc_word = 32'hD63F0000 | {22'd0, r_q.rn, 5'd0};
      ace_pkg::REQ_SXTW:   enc_word = 32'h93407C00 | {22'd0, r_q.rn, r_q.rd};
      ace_pkg::REQ_RET:    enc_word = ace_pkg::OPC_RET;
      ace_pkg::REQ_CLEAR:  enc_word = '0;
      default:             enc_bad  = 1'b1;
    endcase
  end

  // move-wide sequence for a 64-bit constant
  always_comb begin
    case (cmd_i.part)
      2'd0:    const_part = r_q.wide[15:0];
      2'd1:    const_part = r_q.wide[31:16];
      2'd2:    const_part = r_q.wide[47:32];
      default: const_part = r_q.wide[63:48];
    endcase
    const_word = ((cmd_i.part == 2'd0) ? ace_pkg::OPC_MOVZ : ace_pkg::OPC_MOVK)
               | {9'd0, cmd_i.part, const_part, r_q.rd};
  end

  // branch patch
  always_comb begin
    delta      = $signed({1'b0, r_q.target}) - $signed({2'b00, r_q.at});
    patch_bad  = (ace_pkg::CMP_W'(r_q.at) >= ace_pkg::CMP_W'(fill_q))
              || (ace_pkg::CMP_W'(r_q.target) > ace_pkg::CMP_W'(fill_q))
              || (ace_pkg::CMP_W'(r_q.at) >= ace_pkg::CMP_W'(ace_pkg::CODE_DEPTH));
    if (r_q.cond) begin
      patch_word = (rd_data_q & ace_pkg::MASK_KEEP_B19)
                 | {8'd0, {5{delta[13]}}, delta, 5'd0};
    end else begin
      patch_word = (rd_data_q & ace_pkg::MASK_KEEP_B26)
                 | {6'd0, {12{delta[13]}}, delta};
    end
  end

  always_comb begin
    fill_d   = fill_q;
    word_d   = '0;
    index_d  = '0;
    status_d = ace_pkg::STATUS_OK;
    last_d   = 1'b1;
    wr_en    = 1'b0;
    wr_addr  = ace_pkg::IDX_W'(fill_q);
    wr_data  = enc_word;
    if (cmd_i.emit_patch) begin
      if (patch_bad) begin
        status_d = ace_pkg::STATUS_PATCH;
      end else begin
        word_d  = patch_word;
        index_d = r_q.at;
        wr_en   = 1'b1;
        wr_addr = ace_pkg::IDX_W'(r_q.at);
        wr_data = patch_word;
      end
    end else if (cmd_i.emit_single && enc_bad) begin
      status_d = ace_pkg::STATUS_BAD;
    end else if (cmd_i.emit_single && (r_q.req_type == ace_pkg::REQ_CLEAR)) begin
      fill_d = '0;
    end else if (cmd_i.emit_single || cmd_i.emit_const) begin
      wr_data = cmd_i.emit_const ? const_word : enc_word;
      word_d  = wr_data;
      if (full) begin
        status_d = ace_pkg::STATUS_FULL;
      end else begin
        wr_en   = 1'b1;
        index_d = 12'(fill_q);
        last_d  = cmd_i.emit_single || (cmd_i.part == 2'd3);
        fill_d  = fill_q + ace_pkg::FILL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) code_store[wr_addr] <= wr_data;
    if (cmd_i.patch_read) rd_data_q <= code_store[ace_pkg::IDX_W'(r_q.at)];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (emit) begin
        fill_q      <= fill_d;
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      word_q   <= word_d;
      index_q  <= index_d;
      status_q <= status_d;
      last_q   <= last_d;
    end
  end

  assign res_o.valid      = out_valid_q;
  assign res_o.code_word  = word_q;
  assign res_o.word_index = index_q;
  assign res_o.status     = status_q;
  assign res_o.last       = last_q;

endmodule

[rtl/core/arm64_code_emitter_core.sv]
// channel  dir  handshake         payload
// req_i    in   valid/ready       req_type .. patch_conditional
// res_o    out  valid/ready       code_word, word_index, status, last
//
// a request is taken in the idle cycle and worked on in the next ones
// single-word requests are emitted from exec, a branch patch after a registered store
// read before write back, a 64-bit constant one move-wide word a cycle unless stalled
// results sit in an output register, so the next transaction is taken while one waits
// a stalled output holds the sequencer; reset clears the fill count, store contents stay

module arm64_code_emitter_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  ace_req_if.sink   req_i,
  ace_res_if.source res_o
);

  ace_pkg::ctrl_cmd_t cmd;
  ace_pkg::dp_stat_t  stat;
  logic               in_ready;

  ace_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (req_i.valid),
    .in_ready_o (in_ready),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  ace_dpath u_dpath (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_i),
    .res_o  (res_o),
    .cmd_i  (cmd),
    .stat_o (stat)
  );

  assign req_i.ready = in_ready;

endmodule
